/* hdl/sha256_pkg.sv */
// shared types, constants and round functions of the sha-256 hasher
package sha256_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned HASH_WORDS = 8;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [3:0]  POS_LEN_HI = 4'd14;
    localparam logic [3:0]  POS_LAST   = 4'd15;
    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [2:0]  IDX_LAST   = 3'd7;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } t_state;

    // source of the word shifted into the block buffer
    typedef enum logic [2:0] {
        SRC_WORD,
        SRC_LAST,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    typedef struct packed {
        logic        push;
        t_src        src;
        logic        add_len;
        logic        load_work;
        logic        round_en;
        logic [5:0]  round_idx;
        logic        update;
        logic        restart;
        logic [2:0]  out_idx;
    } t_cmd;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
        ror = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
        big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
        big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_s0(input logic [WORD_W-1:0] x);
        small_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_s1(input logic [WORD_W-1:0] x);
        small_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    // byte count above four counts as four
    function automatic logic [2:0] clamp_count(input logic [2:0] c);
        clamp_count = (c > FULL_BYTES) ? FULL_BYTES : c;
    endfunction

    // final word: keep the valid bytes; if fewer than four, put the pad byte right after them
    function automatic logic [WORD_W-1:0] last_word(input logic [WORD_W-1:0] w,
                                                    input logic [2:0] c);
        logic [2:0] cc;
        cc = clamp_count(c);
        unique case (cc)
            3'd0:    last_word = {PAD_BYTE, 24'h0};
            3'd1:    last_word = {w[31:24], PAD_BYTE, 16'h0};
            3'd2:    last_word = {w[31:16], PAD_BYTE, 8'h0};
            3'd3:    last_word = {w[31:8], PAD_BYTE};
            default: last_word = w;
        endcase
    endfunction

endpackage

/* hdl/sha256_hasher.sv */
// sha-256 hasher top level: controller and datapath over valid/ready channels
// a non-final word is taken while idle; every 16th word adds the rounds
//   and a hash update before the next word is taken
// final word: padding, one or two compressions, then 8 digest words
// compression rate is set by the single round unit doing one round per cycle
// reset (i_rst_n low, synchronous): hash words take the initial values, length and
//   word position clear, controller goes idle; the block buffer is not cleared
module sha256_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    // commands from the controller steer every datapath register
    sha256_pkg::t_cmd cmd;

    // controller: fsm, word position, padding order, round and readout counters
    sha256_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_word   (i_last_word),
        .i_byte_count  (i_byte_count),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word_index  (o_word_index),
        .o_digest_last (o_digest_last),
        .o_cmd         (cmd)
    );

    // datapath: 16-word window doubles as block buffer and message schedule,
    // working variables a..h, hash words and 64-bit bit length
    sha256_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_digest_word  (o_digest_word)
    );

endmodule

/* hdl/sha256_dp.sv */
// sha-256 datapath: block buffer / schedule window, round registers, hash words, length
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [31:0]         i_message_word,
    input  logic [2:0]          i_byte_count,
    input  logic                i_last_word,
    output logic [31:0]         o_digest_word
);

    logic [31:0] r_w    [16];
    logic [31:0] r_v    [8];
    logic [31:0] r_hash [8];
    logic [63:0] r_bits;

    logic [31:0] n_push;
    logic [31:0] n_sched;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [63:0] n_len_add;

    always_comb begin
        unique case (i_cmd.src)
            sha256_pkg::SRC_WORD:   n_push = i_message_word;
            sha256_pkg::SRC_LAST:   n_push = sha256_pkg::last_word(i_message_word,
                                                                   i_byte_count);
            sha256_pkg::SRC_MARK:   n_push = {sha256_pkg::PAD_BYTE, 24'h0};
            sha256_pkg::SRC_LEN_HI: n_push = r_bits[63:32];
            sha256_pkg::SRC_LEN_LO: n_push = r_bits[31:0];
            default:                n_push = 32'h0;
        endcase
    end

    assign n_len_add = i_last_word
        ? {58'h0, sha256_pkg::clamp_count(i_byte_count), 3'b000}
        : 64'd32;

    assign n_sched = sha256_pkg::small_s1(r_w[14]) + r_w[9]
                   + sha256_pkg::small_s0(r_w[1]) + r_w[0];

    assign n_t1 = r_v[7] + sha256_pkg::big_s1(r_v[4])
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + sha256_pkg::ROUND_K[i_cmd.round_idx] + r_w[0];
    assign n_t2 = sha256_pkg::big_s0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // window shifts on every push and every round
    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_cmd.push ? n_push : n_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha256_pkg::INIT_HASH[i];
            end
            r_bits <= 64'h0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end
            if (i_cmd.add_len) begin
                r_bits <= r_bits + n_len_add;
            end
        end
    end

    assign o_digest_word = r_hash[i_cmd.out_idx];

endmodule

/* hdl/sha256_ctrl.sv */
// sha-256 controller: word position, padding sequence, round count, digest readout
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_last_word,
    input  logic [2:0]          i_byte_count,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_word_index,
    output logic                o_digest_last,
    output sha256_pkg::t_cmd    o_cmd
);

    sha256_pkg::t_state r_state, n_state;
    logic [3:0] r_pos;
    logic [5:0] r_round;
    logic [2:0] r_out_idx;
    logic       r_marker;
    logic       r_len_hi;
    logic       r_final;
    logic       r_pad;

    logic accept_in;
    logic accept_out;
    logic push_en;
    logic wrap;

    assign o_in_ready  = (r_state == sha256_pkg::ST_IDLE);
    assign o_out_valid = (r_state == sha256_pkg::ST_OUTPUT);
    assign accept_in   = i_in_valid && o_in_ready;
    assign accept_out  = o_out_valid && i_out_ready;
    // a word enters the window on an accepted item or on any padding cycle
    assign push_en     = accept_in || (r_state == sha256_pkg::ST_PAD);
    assign wrap        = push_en && (r_pos == sha256_pkg::POS_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (accept_in) begin
                    if (wrap)             n_state = sha256_pkg::ST_ROUND;
                    else if (i_last_word) n_state = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD: begin
                if (wrap) n_state = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND: begin
                if (r_round == sha256_pkg::ROUND_LAST) n_state = sha256_pkg::ST_UPDATE;
            end
            sha256_pkg::ST_UPDATE: begin
                if (r_final)    n_state = sha256_pkg::ST_OUTPUT;
                else if (r_pad) n_state = sha256_pkg::ST_PAD;
                else            n_state = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_OUTPUT: begin
                if (accept_out && r_out_idx == sha256_pkg::IDX_LAST) begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.src       = sha256_pkg::SRC_ZERO;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_out_idx;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_cmd.push    = accept_in;
                o_cmd.add_len = accept_in;
                o_cmd.src     = i_last_word ? sha256_pkg::SRC_LAST : sha256_pkg::SRC_WORD;
            end
            sha256_pkg::ST_PAD: begin
                o_cmd.push = 1'b1;
                priority if (r_marker)                          o_cmd.src = sha256_pkg::SRC_MARK;
                else if (r_pos == sha256_pkg::POS_LEN_HI)       o_cmd.src = sha256_pkg::SRC_LEN_HI;
                else if (r_pos == sha256_pkg::POS_LAST && r_len_hi)
                                                                o_cmd.src = sha256_pkg::SRC_LEN_LO;
                else                                            o_cmd.src = sha256_pkg::SRC_ZERO;
            end
            sha256_pkg::ST_ROUND:  o_cmd.round_en = 1'b1;
            sha256_pkg::ST_UPDATE: o_cmd.update   = 1'b1;
            sha256_pkg::ST_OUTPUT: begin
                o_cmd.restart = accept_out && (r_out_idx == sha256_pkg::IDX_LAST);
            end
            default: ;
        endcase
        o_cmd.load_work = wrap;
    end

    assign o_word_index  = r_out_idx;
    assign o_digest_last = (r_out_idx == sha256_pkg::IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha256_pkg::ST_IDLE;
            r_pos     <= 4'd0;
            r_round   <= 6'd0;
            r_out_idx <= 3'd0;
            r_marker  <= 1'b0;
            r_len_hi  <= 1'b0;
            r_final   <= 1'b0;
            r_pad     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.push) r_pos <= r_pos + 4'd1;
            if (o_cmd.round_en) r_round <= r_round + 6'd1;
            if (accept_out) r_out_idx <= r_out_idx + 3'd1;
            if (accept_in && i_last_word) begin
                r_pad    <= 1'b1;
                r_marker <= (sha256_pkg::clamp_count(i_byte_count) == sha256_pkg::FULL_BYTES);
            end
            if (r_state == sha256_pkg::ST_PAD) begin
                unique case (o_cmd.src)
                    sha256_pkg::SRC_MARK:   r_marker <= 1'b0;
                    sha256_pkg::SRC_LEN_HI: r_len_hi <= 1'b1;
                    sha256_pkg::SRC_LEN_LO: begin
                        r_len_hi <= 1'b0;
                        r_final  <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (o_cmd.restart) begin
                r_final <= 1'b0;
                r_pad   <= 1'b0;
            end
        end
    end

    // the two sides never open at once
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    // compression ends only after the last round
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_UPDATE) |->
            ($past(r_state) == sha256_pkg::ST_ROUND && $past(r_round) == sha256_pkg::ROUND_LAST))
        else $error("update without a full set of rounds");

    // digest is read out only on a block boundary with padding complete
    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos == 4'd0 && !r_len_hi && !r_marker))
        else $error("digest readout mid block");

    // readout keeps going until the eighth word
    a_out_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_out && !o_digest_last) |=> o_out_valid)
        else $error("digest readout cut short");

endmodule
